[src/ubxr_pkg.sv]
// Shared types and constants for the binary frame receiver.
// No dependencies; used by every module of the block.
package ubxr_pkg;

  // Frame sync pattern
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Stream and register port widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // Register indexes (word address)
  localparam logic [1:0] REG_MAX_LEN  = 2'd0;
  localparam logic [1:0] REG_REJECT_A = 2'd1;
  localparam logic [1:0] REG_REJECT_B = 2'd2;
  localparam logic [1:0] REG_REJECT_EN = 2'd3;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_CKSUM = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] max_payload_len;
    logic [7:0]  reject_class_a;
    logic [7:0]  reject_class_b;
    logic [1:0]  reject_enable;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    status_t     status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [47:0] frame_time;
  } result_t;

endpackage

[src/ubxr_parser.sv]
// Front end: frame state machine with running Fletcher checksum.
// Depends on ubxr_pkg; emits at most one result item per accepted byte.
module ubxr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  ubxr_pkg::cfg_t   cfg,
  input  logic             in_fire,
  input  logic [7:0]       rx_byte,
  input  logic [47:0]      time_stamp,
  output logic             res_push,
  output ubxr_pkg::result_t res
);

  ubxr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  rx_sum_a_r, rx_sum_a_nxt;
  logic [47:0] start_time_r, start_time_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        reject_hit;

  // Running checksum step and length helpers
  assign add_a      = sum_a_r + rx_byte;
  assign add_b      = sum_b_r + add_a;
  assign len_full   = {rx_byte, len_r[7:0]};
  assign count_inc  = count_r + 16'd1;
  assign reject_hit = (cfg.reject_enable[0] && (rx_byte == cfg.reject_class_a)) ||
                      (cfg.reject_enable[1] && (rx_byte == cfg.reject_class_b));

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ubxr_pkg::PH_SYNC1;
      class_r      <= '0;
      id_r         <= '0;
      len_r        <= '0;
      count_r      <= '0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      rx_sum_a_r   <= '0;
      start_time_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      class_r      <= class_nxt;
      id_r         <= id_nxt;
      len_r        <= len_nxt;
      count_r      <= count_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      rx_sum_a_r   <= rx_sum_a_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  // Next state and result item
  always_comb begin
    phase_nxt      = phase_r;
    class_nxt      = class_r;
    id_nxt         = id_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    rx_sum_a_nxt   = rx_sum_a_r;
    start_time_nxt = start_time_r;
    res_push       = 1'b0;

    res.kind           = ubxr_pkg::KIND_VERDICT;
    res.payload_byte   = '0;
    res.payload_index  = '0;
    res.status         = ubxr_pkg::ST_GOOD;
    res.msg_class      = class_r;
    res.msg_id         = id_r;
    res.payload_length = len_r;
    res.frame_time     = start_time_r;

    if (in_fire) begin
      case (phase_r)
        ubxr_pkg::PH_SYNC2: begin
          phase_nxt = (rx_byte == ubxr_pkg::SYNC_SECOND) ? ubxr_pkg::PH_CLASS
                                                         : ubxr_pkg::PH_SYNC1;
        end
        ubxr_pkg::PH_CLASS: begin
          if (reject_hit) begin
            // Abort the frame with the offending class
            res_push           = 1'b1;
            res.status         = ubxr_pkg::ST_REJECTED;
            res.msg_class      = rx_byte;
            res.msg_id         = '0;
            res.payload_length = '0;
            phase_nxt          = ubxr_pkg::PH_SYNC1;
          end else begin
            class_nxt = rx_byte;
            sum_a_nxt = rx_byte;
            sum_b_nxt = rx_byte;
            phase_nxt = ubxr_pkg::PH_ID;
          end
        end
        ubxr_pkg::PH_ID: begin
          id_nxt    = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxr_pkg::PH_LEN1;
        end
        ubxr_pkg::PH_LEN1: begin
          len_nxt   = {8'd0, rx_byte};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubxr_pkg::PH_LEN2;
        end
        ubxr_pkg::PH_LEN2: begin
          len_nxt   = len_full;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          count_nxt = '0;
          if (len_full > cfg.max_payload_len) begin
            res_push           = 1'b1;
            res.status         = ubxr_pkg::ST_TOO_LONG;
            res.payload_length = len_full;
            phase_nxt          = ubxr_pkg::PH_SYNC1;
          end else if (len_full == 16'd0) begin
            phase_nxt = ubxr_pkg::PH_CKA;
          end else begin
            phase_nxt = ubxr_pkg::PH_PAYLOAD;
          end
        end
        ubxr_pkg::PH_PAYLOAD: begin
          sum_a_nxt         = add_a;
          sum_b_nxt         = add_b;
          res_push          = 1'b1;
          res.kind          = ubxr_pkg::KIND_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = count_r;
          count_nxt         = count_inc;
          if (count_inc >= len_r) begin
            phase_nxt = ubxr_pkg::PH_CKA;
          end
        end
        ubxr_pkg::PH_CKA: begin
          rx_sum_a_nxt = rx_byte;
          phase_nxt    = ubxr_pkg::PH_CKB;
        end
        ubxr_pkg::PH_CKB: begin
          res_push   = 1'b1;
          res.status = ((rx_sum_a_r == sum_a_r) && (rx_byte == sum_b_r)) ?
                       ubxr_pkg::ST_GOOD : ubxr_pkg::ST_BAD_CKSUM;
          phase_nxt  = ubxr_pkg::PH_SYNC1;
        end
        default: begin
          // Hunt for the first sync byte and latch its time
          phase_nxt = ubxr_pkg::PH_SYNC1;
          if (rx_byte == ubxr_pkg::SYNC_FIRST) begin
            start_time_nxt = time_stamp;
            phase_nxt      = ubxr_pkg::PH_SYNC2;
          end
        end
      endcase
    end
  end

endmodule

[src/ubxr_queue.sv]
// Back end: short result queue that drives the output channel.
// Depends on ubxr_pkg for the result item type.
module ubxr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ubxr_pkg::result_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output ubxr_pkg::result_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ubxr_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push;
  logic do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/ubx_frame_receiver.sv]
// Top level of the binary frame receiver: register port, parser and result queue.
// Depends on ubxr_pkg, ubxr_parser and ubxr_queue.
//
// Usage:
//   in_*  : one received byte per item, tdata = {time_stamp[47:0], rx_byte[7:0]}.
//   out_* : result items; tuser = kind (0 payload byte, 1 frame verdict),
//           tdata carries byte, index, status, class, id, length and frame time.
//   cfg_* : APB-style register port, words at byte address 4*index; write only
//           while no item is in flight.
// Throughput: one byte per cycle while the result queue is not full; the parser
// updates its checksum and phase in the cycle the byte is accepted.
// Each result item is written into the result queue at the accepting edge and
// offered on out_ from the queue head.
// Reset (synchronous, rst_n low) returns the parser to sync hunting, empties
// the queue and restores register defaults (max payload length 1024).
// When the receiver stalls, results collect in a QUEUE_DEPTH-item queue;
// in_tready drops only once that queue is full.
module ubx_frame_receiver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // rx_byte [7:0], time_stamp [55:8]
  input  logic [ubxr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // payload_byte [7:0], payload_index [23:8], status [25:24], msg_class [33:26],
  // msg_id [41:34], payload_length [57:42], frame_time [105:58], zero [111:106]
  output logic [ubxr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // kind [0]
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ubxr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ubxr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ubxr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  ubxr_pkg::cfg_t    cfg_r, cfg_nxt;
  ubxr_pkg::result_t res;
  ubxr_pkg::result_t head;
  logic              res_push;
  logic              q_full;
  logic              in_fire;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready  = !q_full;
  assign in_fire    = in_tvalid && in_tready;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        ubxr_pkg::REG_MAX_LEN:   cfg_nxt.max_payload_len = cfg_pwdata[15:0];
        ubxr_pkg::REG_REJECT_A:  cfg_nxt.reject_class_a  = cfg_pwdata[7:0];
        ubxr_pkg::REG_REJECT_B:  cfg_nxt.reject_class_b  = cfg_pwdata[7:0];
        ubxr_pkg::REG_REJECT_EN: cfg_nxt.reject_enable   = cfg_pwdata[1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload_len <= ubxr_pkg::MAX_LEN_RESET;
      cfg_r.reject_class_a  <= '0;
      cfg_r.reject_class_b  <= '0;
      cfg_r.reject_enable   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[3:2])
      ubxr_pkg::REG_MAX_LEN:   cfg_prdata = {16'd0, cfg_r.max_payload_len};
      ubxr_pkg::REG_REJECT_A:  cfg_prdata = {24'd0, cfg_r.reject_class_a};
      ubxr_pkg::REG_REJECT_B:  cfg_prdata = {24'd0, cfg_r.reject_class_b};
      ubxr_pkg::REG_REJECT_EN: cfg_prdata = {30'd0, cfg_r.reject_enable};
      default:                 cfg_prdata = '0;
    endcase
  end

  ubxr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_fire    (in_fire),
    .rx_byte    (in_tdata[7:0]),
    .time_stamp (in_tdata[55:8]),
    .res_push   (res_push),
    .res        (res)
  );

  ubxr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .pop       (out_tready),
    .full      (q_full),
    .not_empty (out_tvalid),
    .head      (head)
  );

  // Pack the head item onto the output channel
  assign out_tuser = head.kind;
  assign out_tdata = {6'd0, head.frame_time, head.payload_length, head.msg_id,
                      head.msg_class, head.status, head.payload_index,
                      head.payload_byte};

endmodule

[src/ubxr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
// Depends on ubxr_pkg and ubx_frame_receiver.
module ubxr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic [111:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tvalid,
  input logic         out_tready
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed or dropped");

  // Come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue not empty after reset");

  // Payload index stays below the declared length
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ubxr_pkg::KIND_PAYLOAD) |->
      out_tdata[23:8] < out_tdata[57:42])
    else $error("payload index beyond frame length");

  // Rejected class verdict carries no id and no length
  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ubxr_pkg::KIND_VERDICT) &&
      (out_tdata[25:24] == ubxr_pkg::ST_REJECTED) |->
      (out_tdata[41:34] == 8'd0) && (out_tdata[57:42] == 16'd0))
    else $error("rejected class verdict has id or length");

endmodule

bind ubx_frame_receiver ubxr_checker u_ubxr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[tb/tb_ubx_frame_receiver.sv]
// Self-checking testbench for the binary frame receiver: frame parsing, Fletcher check
// and verdicts, checked against an in-bench predictor. Depends on ubxr_pkg and
// ubx_frame_receiver.
`timescale 1ns / 100ps

module tb_ubx_frame_receiver;

  localparam int CYCLE_LIMIT = 500000;

  logic                             clk;
  logic                             rst_n;
  logic [ubxr_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [ubxr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [ubxr_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [ubxr_pkg::CFG_DATA_W-1:0]  cfg_pwdata;
  logic [ubxr_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  // Register mirror
  logic [15:0] max_len;
  logic [7:0]  rej_a;
  logic [7:0]  rej_b;
  logic [1:0]  rej_en;

  // Parser mirror
  ubxr_pkg::phase_t rx_phase;
  logic [7:0]  rx_class;
  logic [7:0]  rx_id;
  logic [15:0] rx_len;
  logic [15:0] rx_count;
  logic [7:0]  ck_a;
  logic [7:0]  ck_b;
  logic [7:0]  rx_ck_a;
  logic [47:0] rx_time;

  ubxr_pkg::result_t results_pending[$];
  int          mismatches;
  int          bytes_sent;
  int          cycle_count;
  bit          in_gaps_on;
  bit          out_stalls_on;
  logic [47:0] stamp_now;

  ubx_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ubx_frame_receiver: mismatch");
      $finish;
    end
  end

  // Fold one byte into the running Fletcher pair
  function automatic void fletcher_add(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endfunction

  // Advance the parser mirror by one byte; return 1 when a result item is due
  function automatic bit predict_rx(input logic [7:0] b, input logic [47:0] ts,
                                    output ubxr_pkg::result_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    r.msg_class      = rx_class;
    r.msg_id         = rx_id;
    r.payload_length = rx_len;
    r.frame_time     = rx_time;
    case (rx_phase)
      ubxr_pkg::PH_SYNC2: begin
        rx_phase = (b == ubxr_pkg::SYNC_SECOND) ? ubxr_pkg::PH_CLASS : ubxr_pkg::PH_SYNC1;
      end
      ubxr_pkg::PH_CLASS: begin
        if ((rej_en[0] && b == rej_a) || (rej_en[1] && b == rej_b)) begin
          r.kind           = ubxr_pkg::KIND_VERDICT;
          r.status         = ubxr_pkg::ST_REJECTED;
          r.msg_class      = b;
          r.msg_id         = 8'd0;
          r.payload_length = 16'd0;
          hit              = 1'b1;
          rx_phase         = ubxr_pkg::PH_SYNC1;
        end else begin
          rx_class = b;
          ck_a     = 8'd0;
          ck_b     = 8'd0;
          fletcher_add(b);
          rx_phase = ubxr_pkg::PH_ID;
        end
      end
      ubxr_pkg::PH_ID: begin
        rx_id = b;
        fletcher_add(b);
        rx_phase = ubxr_pkg::PH_LEN1;
      end
      ubxr_pkg::PH_LEN1: begin
        rx_len = {8'd0, b};
        fletcher_add(b);
        rx_phase = ubxr_pkg::PH_LEN2;
      end
      ubxr_pkg::PH_LEN2: begin
        rx_len = {b, rx_len[7:0]};
        fletcher_add(b);
        rx_count = 16'd0;
        if (rx_len > max_len) begin
          r.kind           = ubxr_pkg::KIND_VERDICT;
          r.status         = ubxr_pkg::ST_TOO_LONG;
          r.payload_length = rx_len;
          hit              = 1'b1;
          rx_phase         = ubxr_pkg::PH_SYNC1;
        end else if (rx_len == 16'd0) begin
          // empty payload: checksum follows at once
          rx_phase = ubxr_pkg::PH_CKA;
        end else begin
          rx_phase = ubxr_pkg::PH_PAYLOAD;
        end
      end
      ubxr_pkg::PH_PAYLOAD: begin
        fletcher_add(b);
        r.kind          = ubxr_pkg::KIND_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = rx_count;
        r.status        = ubxr_pkg::ST_GOOD;
        hit             = 1'b1;
        rx_count        = rx_count + 16'd1;
        if (rx_count >= rx_len) rx_phase = ubxr_pkg::PH_CKA;
      end
      ubxr_pkg::PH_CKA: begin
        rx_ck_a  = b;
        rx_phase = ubxr_pkg::PH_CKB;
      end
      ubxr_pkg::PH_CKB: begin
        r.kind   = ubxr_pkg::KIND_VERDICT;
        r.status = (rx_ck_a == ck_a && b == ck_b) ? ubxr_pkg::ST_GOOD
                                                  : ubxr_pkg::ST_BAD_CKSUM;
        hit      = 1'b1;
        rx_phase = ubxr_pkg::PH_SYNC1;
      end
      default: begin
        // hunt for the first sync byte and latch its time
        rx_phase = ubxr_pkg::PH_SYNC1;
        if (b == ubxr_pkg::SYNC_FIRST) begin
          rx_time  = ts;
          rx_phase = ubxr_pkg::PH_SYNC2;
        end
      end
    endcase
    return hit;
  endfunction

  // Hand out a timestamp, mostly increasing with an occasional jump
  function automatic logic [47:0] next_stamp();
    logic [47:0] s;
    logic [63:0] w;
    s = stamp_now;
    stamp_now = stamp_now + 48'($urandom_range(1, 3000));
    if ($urandom_range(0, 63) == 0) begin
      w = {$urandom, $urandom};
      stamp_now = w[47:0];
    end
    return s;
  endfunction

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic [47:0] ts);
    ubxr_pkg::result_t r;
    int gap;
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {ts, b};
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (predict_rx(b, ts, r)) results_pending.push_back(r);
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic hold_and_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rb_want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      ubxr_pkg::REG_MAX_LEN: begin
        max_len = value[15:0];
        rb_want = {16'd0, max_len};
      end
      ubxr_pkg::REG_REJECT_A: begin
        rej_a   = value[7:0];
        rb_want = {24'd0, rej_a};
      end
      ubxr_pkg::REG_REJECT_B: begin
        rej_b   = value[7:0];
        rb_want = {24'd0, rej_b};
      end
      default: begin
        rej_en  = value[1:0];
        rb_want = {30'd0, rej_en};
      end
    endcase
    // read back through a fresh setup and access pair
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== rb_want) begin
      $error("register %0d readback: expected 0x%0h, got 0x%0h", idx, rb_want,
             cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Build a frame and send it; header only when the mirror says it aborts,
  // cut >= 0 truncates the frame to that many bytes
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input bit corrupt, input int cut);
    logic [7:0] fb[$];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] flip;
    int i;
    sa = 8'd0;
    sb = 8'd0;
    fb.push_back(ubxr_pkg::SYNC_FIRST);
    fb.push_back(ubxr_pkg::SYNC_SECOND);
    fb.push_back(cls);
    if (!((rej_en[0] && cls == rej_a) || (rej_en[1] && cls == rej_b))) begin
      fb.push_back(id);
      fb.push_back(len[7:0]);
      fb.push_back(len[15:8]);
      if (len <= max_len) begin
        for (i = 0; i < int'(len); i++) fb.push_back(8'($urandom_range(0, 255)));
        for (i = 2; i < fb.size(); i++) begin
          sa = sa + fb[i];
          sb = sb + sa;
        end
        if (corrupt) begin
          flip = 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) == 0) sa = sa ^ flip;
          else sb = sb ^ flip;
        end
        fb.push_back(sa);
        fb.push_back(sb);
      end
    end
    while (cut >= 0 && fb.size() > cut) void'(fb.pop_back());
    foreach (fb[k]) send_byte(fb[k], next_stamp());
  endtask

  // Send one random unit: mostly clean frames, plus corrupt, truncated,
  // oversized and rejected frames and line noise
  task automatic send_random_unit();
    int pick;
    int n;
    logic [15:0] len;
    logic [7:0] cls;
    pick = $urandom_range(0, 99);
    cls  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) len = 16'($urandom_range(0, 200));
    else len = 16'($urandom_range(0, 12));
    if (len > max_len) len = max_len;
    if (pick < 60) begin
      send_frame(cls, 8'($urandom_range(0, 255)), len, 1'b0, -1);
    end else if (pick < 70) begin
      send_frame(cls, 8'($urandom_range(0, 255)), len, 1'b1, -1);
    end else if (pick < 78) begin
      send_frame(cls, 8'($urandom_range(0, 255)), len, 1'b0,
                 $urandom_range(1, 7 + int'(len)));
    end else if (pick < 86) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0, 1:    send_byte(ubxr_pkg::SYNC_FIRST, next_stamp());
          2:       send_byte(ubxr_pkg::SYNC_SECOND, next_stamp());
          default: send_byte(8'($urandom_range(0, 255)), next_stamp());
        endcase
      end
    end else if (pick < 93 && max_len != 16'hFFFF) begin
      len = 16'($urandom_range(int'(max_len) + 1, 65535));
      send_frame(cls, 8'($urandom_range(0, 255)), len, 1'b0, -1);
    end else begin
      cls = $urandom_range(0, 1) ? rej_a : rej_b;
      send_frame(cls, 8'($urandom_range(0, 255)), len, 1'b0, -1);
    end
  endtask

  // Directed frames: extremes, each verdict and the special cases
  task automatic test_directed_frames();
    // good empty frame, first sync stamped zero
    stamp_now = 48'h0;
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0, -1);
    // one payload byte with a broken checksum, first sync stamped all ones
    stamp_now = 48'hFFFF_FFFF_FFFF;
    send_frame(8'h00, 8'hFF, 16'd1, 1'b1, -1);
    // bad second sync byte, then a stray byte
    send_byte(ubxr_pkg::SYNC_FIRST, next_stamp());
    send_byte(ubxr_pkg::SYNC_FIRST, next_stamp());
    send_byte(8'h00, next_stamp());
    // rejected class
    hold_and_drain();
    cfg_write(ubxr_pkg::REG_REJECT_A, 32'h06);
    cfg_write(ubxr_pkg::REG_REJECT_EN, 32'h1);
    send_frame(8'h06, 8'h01, 16'd0, 1'b0, -1);
    // declared length over the limit
    hold_and_drain();
    cfg_write(ubxr_pkg::REG_MAX_LEN, 32'h0);
    send_frame(8'h01, 8'h02, 16'hFFFF, 1'b0, -1);
  endtask

  // Random traffic over several register settings, extremes among them
  task automatic test_random_traffic(input int n_phases, input int per_phase);
    int ph;
    int start;
    logic [15:0] mx;
    for (ph = 0; ph < n_phases; ph++) begin
      hold_and_drain();
      case (ph % 4)
        0:       mx = 16'hFFFF;
        1:       mx = 16'd0;
        2:       mx = 16'($urandom_range(1, 40));
        default: mx = ubxr_pkg::MAX_LEN_RESET;
      endcase
      cfg_write(ubxr_pkg::REG_MAX_LEN, {16'd0, mx});
      cfg_write(ubxr_pkg::REG_REJECT_A,
                (ph == 1) ? 32'h00 : (ph == 2) ? 32'hFF : $urandom_range(0, 255));
      cfg_write(ubxr_pkg::REG_REJECT_B,
                (ph == 1) ? 32'hFF : (ph == 2) ? 32'h00 : $urandom_range(0, 255));
      cfg_write(ubxr_pkg::REG_REJECT_EN, 32'((ph + 1) % 4));
      start = bytes_sent;
      while (bytes_sent - start < per_phase) send_random_unit();
    end
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_saturated_traffic(input int n_items);
    int start;
    hold_and_drain();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    cfg_write(ubxr_pkg::REG_MAX_LEN, {16'd0, ubxr_pkg::MAX_LEN_RESET});
    cfg_write(ubxr_pkg::REG_REJECT_EN, 32'h3);
    start = bytes_sent;
    while (bytes_sent - start < n_items) send_random_unit();
  endtask

  task automatic check_field(input string name, input logic [47:0] want_v,
                             input logic [47:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Receiver side: stall in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_pending.size() == 0) begin
        $error("unexpected result item: tuser 0x%0h, tdata 0x%0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        check_field("kind", 48'(results_pending[0].kind), 48'(out_tuser));
        check_field("payload_byte", 48'(results_pending[0].payload_byte),
                    48'(out_tdata[7:0]));
        check_field("payload_index", 48'(results_pending[0].payload_index),
                    48'(out_tdata[23:8]));
        check_field("status", 48'(results_pending[0].status), 48'(out_tdata[25:24]));
        check_field("msg_class", 48'(results_pending[0].msg_class),
                    48'(out_tdata[33:26]));
        check_field("msg_id", 48'(results_pending[0].msg_id), 48'(out_tdata[41:34]));
        check_field("payload_length", 48'(results_pending[0].payload_length),
                    48'(out_tdata[57:42]));
        check_field("frame_time", results_pending[0].frame_time, out_tdata[105:58]);
        void'(results_pending.pop_front());
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    cycle_count   = 0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    stamp_now     = 48'h0;
    max_len       = ubxr_pkg::MAX_LEN_RESET;
    rej_a         = 8'd0;
    rej_b         = 8'd0;
    rej_en        = 2'd0;
    rx_phase      = ubxr_pkg::PH_SYNC1;
    rx_class      = 8'd0;
    rx_id         = 8'd0;
    rx_len        = 16'd0;
    rx_count      = 16'd0;
    ck_a          = 8'd0;
    ck_b          = 8'd0;
    rx_ck_a       = 8'd0;
    rx_time       = 48'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_traffic(6, 190);
    test_saturated_traffic(150);

    hold_and_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_pending.size() == 0) begin
      $display("ubx_frame_receiver: match");
    end else begin
      $display("ubx_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
src/ubxr_pkg.sv
src/ubxr_parser.sv
src/ubxr_queue.sv
src/ubx_frame_receiver.sv
src/ubxr_checker.sv
tb/tb_ubx_frame_receiver.sv
